FILE: rtl/rcbf_pkg.sv
// ----------------------------------------------------------------------------
// rcbf_pkg: shared types and constants of the cascaded RC band filter
// Item formats, the stage-to-stage link, register and mode codes, saturation.
// ----------------------------------------------------------------------------
package rcbf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ST_W     = SAMPLE_W + 8;
	localparam int COEF_W   = 16;
	localparam int SAT_IN_W = ST_W + 4;
	localparam int PROD_W   = ST_W + COEF_W + 3;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HP_COEF     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LP_COEF     = 2'd3;

	localparam logic [1:0] MODE_HP = 2'd0;
	localparam logic [1:0] MODE_LP = 2'd1;
	localparam logic [1:0] MODE_BP = 2'd2;

	localparam logic signed [SAT_IN_W-1:0] ST_HI = SAT_IN_W'((2 ** (ST_W - 1)) - 1);
	localparam logic signed [SAT_IN_W-1:0] ST_LO = -ST_HI - SAT_IN_W'(1);
	localparam logic signed [ST_W:0] OUT_HI = (ST_W + 1)'((2 ** (SAMPLE_W - 1)) - 1);
	localparam logic signed [ST_W:0] OUT_LO = -OUT_HI - (ST_W + 1)'(1);
	localparam logic signed [PROD_W-1:0] RND_Q16 = PROD_W'(2 ** (COEF_W - 1));
	localparam logic signed [ST_W:0] RND_OUT = (ST_W + 1)'(128);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       clear_state;
	} src_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       clipped;
	} res_item_t;

	// What one cell hands to the next while an item walks down the chain.
	typedef struct packed {
		logic                   vld;
		logic                   clr;
		logic                   sat;
		logic signed [ST_W-1:0] x;
	} link_t;

	typedef struct packed {
		logic                   active;
		logic [COEF_W-1:0]      coef;
	} cell_ctl_t;

	typedef struct packed {
		logic                   ovf;
		logic signed [ST_W-1:0] val;
	} sat_t;

	function automatic sat_t sat_st(input logic signed [SAT_IN_W-1:0] v);
		sat_t r;
		if (v > ST_HI) begin
			r.ovf = 1'b1;
			r.val = ST_W'(ST_HI);
		end else if (v < ST_LO) begin
			r.ovf = 1'b1;
			r.val = ST_W'(ST_LO);
		end else begin
			r.ovf = 1'b0;
			r.val = ST_W'(v);
		end
		return r;
	endfunction

endpackage

FILE: rtl/cascaded_rc_band_filter_core.sv
// ----------------------------------------------------------------------------
// cascaded_rc_band_filter_core: cascaded first-order RC high/low/band filter
//
//   channel   signals                          direction
//   src       src_valid, src_stall, src_item   item in (sample, clear flag)
//   res       res_valid, res_stall, res_item   item out (sample, clip flag)
//   cfg       cfg_we, cfg_index, cfg_data      register write
//
// An item walks a row of 2*MAX_STAGES cells (high-pass cells, then low-pass
// cells), one cell per cycle, and each cell does one multiply on it. The
// result passes the launch register, the cell registers and the output
// register before it is offered, and the next item is taken only after the
// current one leaves the row. Reset zeroes all stage state and loads the
// register defaults. A stalled result waits in the output register while the
// next item is filtered; the next result then waits in a spare register.
// ----------------------------------------------------------------------------
module cascaded_rc_band_filter_core #(
	parameter int MAX_STAGES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              src_valid,
	output logic                              src_stall,
	input  rcbf_pkg::src_item_t               src_item,
	output logic                              res_valid,
	input  logic                              res_stall,
	output rcbf_pkg::res_item_t               res_item,
	input  logic                              cfg_we,
	input  logic [rcbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcbf_pkg::CFG_W-1:0]        cfg_data
);

	localparam int NCELL = 2 * MAX_STAGES;

	logic [1:0]                  mode_q;
	logic [3:0]                  stage_count_q;
	logic [rcbf_pkg::COEF_W-1:0] hp_coef_q;
	logic [rcbf_pkg::COEF_W-1:0] lp_coef_q;

	logic                        do_hp;
	logic                        do_lp;
	logic [4:0]                  n_eff;
	logic                        src_take;
	logic                        res_free;
	logic                        busy_q;

	rcbf_pkg::link_t             lnk [NCELL+1];
	rcbf_pkg::link_t             launch_q;
	rcbf_pkg::link_t             exit_lnk;
	rcbf_pkg::res_item_t         exit_item;
	rcbf_pkg::res_item_t         res_q;
	rcbf_pkg::res_item_t         pend_q;
	logic                        res_valid_q;
	logic                        pend_vld_q;

	logic signed [rcbf_pkg::ST_W:0] out_rnd;
	logic signed [rcbf_pkg::ST_W:0] out_sh;
	logic                           out_ovf;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= rcbf_pkg::MODE_HP;
			stage_count_q <= 4'd1;
			hp_coef_q     <= '0;
			lp_coef_q     <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				rcbf_pkg::CFG_MODE:        mode_q        <= cfg_data[1:0];
				rcbf_pkg::CFG_STAGE_COUNT: stage_count_q <= cfg_data[3:0];
				rcbf_pkg::CFG_HP_COEF:     hp_coef_q     <= cfg_data;
				rcbf_pkg::CFG_LP_COEF:     lp_coef_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Mode three runs as band-pass; stage count is clamped to 1..MAX_STAGES.
	assign do_hp = (mode_q != rcbf_pkg::MODE_LP);
	assign do_lp = (mode_q != rcbf_pkg::MODE_HP);

	always_comb begin
		if (stage_count_q == 4'd0) begin
			n_eff = 5'd1;
		end else if ({1'b0, stage_count_q} > 5'(MAX_STAGES)) begin
			n_eff = 5'(MAX_STAGES);
		end else begin
			n_eff = {1'b0, stage_count_q};
		end
	end

	// Input side: one item in the row at a time.
	assign src_stall = busy_q | pend_vld_q;
	assign src_take  = src_valid & ~src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
			busy_q   <= 1'b0;
		end else begin
			launch_q.vld <= src_take;
			launch_q.clr <= src_item.clear_state;
			launch_q.sat <= 1'b0;
			launch_q.x   <= {src_item.sample_in, 8'd0};
			if (src_take) begin
				busy_q <= 1'b1;
			end else if (exit_lnk.vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign lnk[0] = launch_q;

	for (genvar i = 0; i < MAX_STAGES; i++) begin : g_hp
		rcbf_pkg::cell_ctl_t ctl;
		assign ctl.active = do_hp & (5'(i) < n_eff);
		assign ctl.coef   = hp_coef_q;
		rcbf_hp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.link_in  (lnk[i]),
			.link_out (lnk[i+1])
		);
	end

	for (genvar i = 0; i < MAX_STAGES; i++) begin : g_lp
		rcbf_pkg::cell_ctl_t ctl;
		assign ctl.active = do_lp & (5'(i) < n_eff);
		assign ctl.coef   = lp_coef_q;
		rcbf_lp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.link_in  (lnk[MAX_STAGES+i]),
			.link_out (lnk[MAX_STAGES+i+1])
		);
	end

	assign exit_lnk = lnk[NCELL];

	// Round the last stage value to the sample format and saturate.
	always_comb begin
		out_rnd = (rcbf_pkg::ST_W + 1)'(exit_lnk.x) + rcbf_pkg::RND_OUT;
		out_sh  = out_rnd >>> 8;
		out_ovf = 1'b0;
		exit_item.sample_out = rcbf_pkg::SAMPLE_W'(out_sh);
		if (out_sh > rcbf_pkg::OUT_HI) begin
			out_ovf = 1'b1;
			exit_item.sample_out = rcbf_pkg::SAMPLE_W'(rcbf_pkg::OUT_HI);
		end else if (out_sh < rcbf_pkg::OUT_LO) begin
			out_ovf = 1'b1;
			exit_item.sample_out = rcbf_pkg::SAMPLE_W'(rcbf_pkg::OUT_LO);
		end
		exit_item.clipped = exit_lnk.sat | out_ovf;
	end

	// Output register plus one spare slot for a result that meets a stall.
	assign res_free = ~res_valid_q | ~res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pend_vld_q  <= 1'b0;
		end else if (res_free) begin
			if (pend_vld_q) begin
				res_valid_q <= 1'b1;
				pend_vld_q  <= 1'b0;
			end else begin
				res_valid_q <= exit_lnk.vld;
			end
		end else if (exit_lnk.vld) begin
			pend_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free) begin
			res_q <= pend_vld_q ? pend_q : exit_item;
		end else if (exit_lnk.vld) begin
			pend_q <= exit_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	a_exit_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_lnk.vld |-> busy_q)
		else $error("item left the cell row with none in flight");

	a_take_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		src_take |=> (busy_q && launch_q.vld))
		else $error("accepted item did not enter the cell row");

	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> res_valid_q)
		else $error("spare slot full while output register empty");

	a_no_spare_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		exit_lnk.vld |-> !pend_vld_q)
		else $error("result arrived while spare slot still full");

endmodule

FILE: rtl/rcbf_hp_cell.sv
// ----------------------------------------------------------------------------
// rcbf_hp_cell: one first-order high-pass stage
// Holds its previous input and output; y = round(a * (y + x - x_prev)).
// ----------------------------------------------------------------------------
module rcbf_hp_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rcbf_pkg::cell_ctl_t ctl,
	input  rcbf_pkg::link_t   link_in,
	output rcbf_pkg::link_t   link_out
);

	logic signed [rcbf_pkg::ST_W-1:0]   y_q;
	logic signed [rcbf_pkg::ST_W-1:0]   prev_q;
	logic signed [rcbf_pkg::ST_W-1:0]   y_eff;
	logic signed [rcbf_pkg::ST_W-1:0]   prev_eff;
	logic signed [rcbf_pkg::ST_W+1:0]   sum;
	logic signed [rcbf_pkg::PROD_W-1:0] prod;
	logic signed [rcbf_pkg::PROD_W-1:0] rnd;
	rcbf_pkg::sat_t                     nxt;
	rcbf_pkg::link_t                    link_q;

	// A clear on the item acts as if the state were zero before the update.
	assign y_eff    = link_in.clr ? '0 : y_q;
	assign prev_eff = link_in.clr ? '0 : prev_q;

	always_comb begin
		sum  = (rcbf_pkg::ST_W + 2)'(y_eff) + (rcbf_pkg::ST_W + 2)'(link_in.x)
			- (rcbf_pkg::ST_W + 2)'(prev_eff);
		prod = rcbf_pkg::PROD_W'(sum)
			* rcbf_pkg::PROD_W'($signed({1'b0, ctl.coef}));
		rnd  = prod + rcbf_pkg::RND_Q16;
		nxt  = rcbf_pkg::sat_st(rcbf_pkg::SAT_IN_W'(rnd >>> rcbf_pkg::COEF_W));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q    <= '0;
			prev_q <= '0;
			link_q <= '0;
		end else begin
			link_q.vld <= link_in.vld;
			link_q.clr <= link_in.clr;
			link_q.sat <= link_in.sat | (ctl.active & nxt.ovf);
			link_q.x   <= ctl.active ? nxt.val : link_in.x;
			if (link_in.vld) begin
				if (ctl.active) begin
					y_q    <= nxt.val;
					prev_q <= link_in.x;
				end else if (link_in.clr) begin
					y_q    <= '0;
					prev_q <= '0;
				end
			end
		end
	end

	assign link_out = link_q;

endmodule

FILE: rtl/rcbf_lp_cell.sv
// ----------------------------------------------------------------------------
// rcbf_lp_cell: one first-order low-pass stage
// Holds its output; y = y + round(b * (x - y)).
// ----------------------------------------------------------------------------
module rcbf_lp_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rcbf_pkg::cell_ctl_t ctl,
	input  rcbf_pkg::link_t   link_in,
	output rcbf_pkg::link_t   link_out
);

	logic signed [rcbf_pkg::ST_W-1:0]   y_q;
	logic signed [rcbf_pkg::ST_W-1:0]   y_eff;
	logic signed [rcbf_pkg::ST_W:0]     diff;
	logic signed [rcbf_pkg::PROD_W-1:0] prod;
	logic signed [rcbf_pkg::PROD_W-1:0] rnd;
	logic signed [rcbf_pkg::SAT_IN_W-1:0] acc;
	rcbf_pkg::sat_t                     nxt;
	rcbf_pkg::link_t                    link_q;

	assign y_eff = link_in.clr ? '0 : y_q;

	always_comb begin
		diff = (rcbf_pkg::ST_W + 1)'(link_in.x) - (rcbf_pkg::ST_W + 1)'(y_eff);
		prod = rcbf_pkg::PROD_W'(diff)
			* rcbf_pkg::PROD_W'($signed({1'b0, ctl.coef}));
		rnd  = prod + rcbf_pkg::RND_Q16;
		acc  = rcbf_pkg::SAT_IN_W'(y_eff)
			+ rcbf_pkg::SAT_IN_W'(rnd >>> rcbf_pkg::COEF_W);
		nxt  = rcbf_pkg::sat_st(acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q    <= '0;
			link_q <= '0;
		end else begin
			link_q.vld <= link_in.vld;
			link_q.clr <= link_in.clr;
			link_q.sat <= link_in.sat | (ctl.active & nxt.ovf);
			link_q.x   <= ctl.active ? nxt.val : link_in.x;
			if (link_in.vld) begin
				if (ctl.active) begin
					y_q <= nxt.val;
				end else if (link_in.clr) begin
					y_q <= '0;
				end
			end
		end
	end

	assign link_out = link_q;

endmodule

FILE: sim/rcbf_result_checker.sv
// ----------------------------------------------------------------------------
// rcbf_result_checker: scoreboard for the cascaded RC band filter core
// Watches the register port and both item channels, keeps its own copy of
// the registers and of every stage's state, works out the result of each
// accepted item and compares the results that leave the block in order.
// ----------------------------------------------------------------------------
module rcbf_result_checker #(
	parameter int STAGES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	input  logic                           src_stall,
	input  rcbf_pkg::src_item_t            src_item,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  rcbf_pkg::res_item_t            res_item,
	input  logic                           cfg_we,
	input  logic [rcbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcbf_pkg::CFG_W-1:0]     cfg_data,
	output int                             fails,
	output int                             pending,
	output int                             compared
);

	localparam int ST_W      = rcbf_pkg::ST_W;
	localparam int SAMPLE_W  = rcbf_pkg::SAMPLE_W;
	localparam int COEF_W    = rcbf_pkg::COEF_W;
	localparam int CFG_W     = rcbf_pkg::CFG_W;
	localparam int CFG_IDX_W = rcbf_pkg::CFG_IDX_W;

	logic [1:0]              mode_r;
	logic [3:0]              stages_r;
	logic [COEF_W-1:0]       hp_a;
	logic [COEF_W-1:0]       lp_b;
	logic signed [ST_W-1:0]  hp_px [STAGES];
	logic signed [ST_W-1:0]  hp_y [STAGES];
	logic signed [ST_W-1:0]  lp_y [STAGES];
	logic                    clip_seen;
	rcbf_pkg::res_item_t     due_results [$];
	rcbf_pkg::res_item_t     want;

	function automatic longint saturate(input longint v, input int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clip_seen = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip_seen = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// Q0.16 product, rounded half up.
	function automatic longint scale_q16(input longint v, input logic [COEF_W-1:0] c);
		return (v * longint'({48'b0, c}) + 32768) >>> 16;
	endfunction

	function automatic void clear_stages();
		int i;
		for (i = 0; i < STAGES; i++) begin
			hp_px[i] = '0;
			hp_y[i] = '0;
			lp_y[i] = '0;
		end
	endfunction

	function automatic rcbf_pkg::res_item_t filter_sample(input rcbf_pkg::src_item_t it);
		longint x, sum, y;
		int n, i;
		rcbf_pkg::res_item_t r;
		clip_seen = 1'b0;
		if (it.clear_state)
			clear_stages();
		n = int'(stages_r);
		if (n == 0)
			n = 1;
		if (n > STAGES)
			n = STAGES;
		x = longint'(it.sample_in) * 256;
		// Mode three behaves as band-pass, so each chain is keyed off the other mode.
		if (mode_r != rcbf_pkg::MODE_LP) begin
			for (i = 0; i < n; i++) begin
				sum = longint'(hp_y[i]) + x - longint'(hp_px[i]);
				hp_y[i] = ST_W'(saturate(scale_q16(sum, hp_a), ST_W));
				hp_px[i] = ST_W'(x);
				x = longint'(hp_y[i]);
			end
		end
		if (mode_r != rcbf_pkg::MODE_HP) begin
			for (i = 0; i < n; i++) begin
				sum = x - longint'(lp_y[i]);
				lp_y[i] = ST_W'(saturate(longint'(lp_y[i]) + scale_q16(sum, lp_b), ST_W));
				x = longint'(lp_y[i]);
			end
		end
		y = saturate((x + 128) >>> 8, SAMPLE_W);
		r.sample_out = SAMPLE_W'(y);
		r.clipped = clip_seen;
		return r;
	endfunction

	function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] d);
		case (idx)
			rcbf_pkg::CFG_MODE:        mode_r = d[1:0];
			rcbf_pkg::CFG_STAGE_COUNT: stages_r = d[3:0];
			rcbf_pkg::CFG_HP_COEF:     hp_a = d;
			rcbf_pkg::CFG_LP_COEF:     lp_b = d;
			default: ;
		endcase
	endfunction

	function automatic void flag_mismatch(input string what, input int exp_v, input int got_v);
		$display("%0t mismatch in %s: expected %0d, got %0d", $time, what, exp_v, got_v);
		fails++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r = rcbf_pkg::MODE_HP;
			stages_r = 4'd1;
			hp_a = '0;
			lp_b = '1;
			clear_stages();
			due_results.delete();
			fails = 0;
			pending = 0;
			compared = 0;
		end else begin
			// Results first, so an item taken at this edge cannot be matched to
			// a result that leaves at the same edge.
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t unexpected result: sample_out %0d clipped %0b",
						$time, res_item.sample_out, res_item.clipped);
					fails++;
				end else begin
					want = due_results.pop_front();
					if (res_item.sample_out !== want.sample_out)
						flag_mismatch("sample_out", want.sample_out, res_item.sample_out);
					if (res_item.clipped !== want.clipped)
						flag_mismatch("clipped", want.clipped, res_item.clipped);
					compared++;
				end
			end
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (src_valid && !src_stall)
				due_results.push_back(filter_sample(src_item));
			pending = due_results.size();
		end
	end

endmodule

FILE: sim/cascaded_rc_band_filter_core_test.sv
// ----------------------------------------------------------------------------
// cascaded_rc_band_filter_core_test: top of the filter core testbench
// Drives register settings and sample items into the core, stalls its output
// on a pattern of its own and leaves all checking to the result checker.
// ----------------------------------------------------------------------------
module cascaded_rc_band_filter_core_test;

	localparam int SAMPLE_W  = rcbf_pkg::SAMPLE_W;
	localparam int CFG_W     = rcbf_pkg::CFG_W;
	localparam int CFG_IDX_W = rcbf_pkg::CFG_IDX_W;

	localparam int ITEM_GOAL = 1700;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 src_valid = 1'b0;
	logic                 src_stall;
	rcbf_pkg::src_item_t  src_item = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	rcbf_pkg::res_item_t  res_item;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = rcbf_pkg::CFG_MODE;
	logic [CFG_W-1:0]     cfg_data = '0;

	int                   fails;
	int                   pending;
	int                   compared;
	int                   items_sent = 0;
	int                   clears_sent = 0;
	int                   settings_used = 0;
	int                   burst_left = 0;
	bit                   hold_req = 1'b0;
	logic signed [SAMPLE_W-1:0] last_sample = '0;

	cascaded_rc_band_filter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rcbf_result_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending),
		.compared  (compared)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic put_item(input logic signed [SAMPLE_W-1:0] s, input logic clr);
		@(negedge clk);
		src_valid <= 1'b1;
		src_item <= '{sample_in: s, clear_state: clr};
		do
			@(posedge clk);
		while (src_stall);
		items_sent++;
		if (clr)
			clears_sent++;
		last_sample = s;
	endtask

	task automatic idle_src(input int n);
		repeat (n) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
	endtask

	// Hold the input quiet until every item sent so far has come back.
	task automatic wait_drained();
		idle_src(1);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] md, input logic [CFG_W-1:0] st,
			input logic [CFG_W-1:0] hp, input logic [CFG_W-1:0] lp);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= rcbf_pkg::CFG_MODE;
		cfg_data <= md;
		@(negedge clk);
		cfg_index <= rcbf_pkg::CFG_STAGE_COUNT;
		cfg_data <= st;
		@(negedge clk);
		cfg_index <= rcbf_pkg::CFG_HP_COEF;
		cfg_data <= hp;
		@(negedge clk);
		cfg_index <= rcbf_pkg::CFG_LP_COEF;
		cfg_data <= lp;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [CFG_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return CFG_W'($urandom_range(60000, 65535));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_stages();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return CFG_W'($urandom_range(1, 8));
		if (r == 8)
			return '0;
		return CFG_W'($urandom_range(9, 15));
	endfunction

	// Occasionally fill the unused upper bits of a narrow register with noise.
	function automatic logic [CFG_W-1:0] add_noise(input logic [CFG_W-1:0] v, input int used);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'($urandom);
		if ($urandom_range(0, 3) != 0)
			return v;
		return (junk << used) | v;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int kind,
			input logic signed [SAMPLE_W-1:0] prev);
		logic signed [SAMPLE_W-1:0] r;
		int v;
		r = SAMPLE_W'($urandom);
		case (kind)
			1: begin
				case ($urandom_range(0, 4))
					0: r = 16'sh7FFF;
					1: r = 16'sh8000;
					2: r = '0;
					3: r = '1;
					default: r = 16'sd1;
				endcase
			end
			2: begin
				// Slow walk, so the low-pass chains get a chance to settle.
				v = int'(prev) + int'($urandom_range(0, 1024)) - 512;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				r = SAMPLE_W'(v);
			end
			3: begin
				// Large swings of alternating sign drive the high-pass chains hard.
				if (prev < 0)
					r = 16'sh7FFF - SAMPLE_W'($urandom_range(0, 255));
				else
					r = 16'sh8000 + SAMPLE_W'($urandom_range(0, 255));
			end
			default: ;
		endcase
		return r;
	endfunction

	// Output side: stall styles change after a random span, and a long
	// hold-off is taken when the stimulus asks for one.
	initial begin
		int style, span;
		@(posedge arst_n);
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(20, 300);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_req) begin
					res_stall <= 1'b1;
					repeat (LONG_HOLD) @(negedge clk);
					hold_req = 1'b0;
				end else begin
					case (style)
						0: res_stall <= 1'b0;
						1: res_stall <= ($urandom_range(0, 3) == 0);
						2: res_stall <= ($urandom_range(0, 3) != 0);
						default: res_stall <= ((k % 8) < 3);
					endcase
				end
			end
		end
	end

	initial begin
		int phase, span, style, kind;
		bit clr;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		idle_src(2);

		// Register defaults straight out of reset.
		put_item(16'sh7FFF, 1'b0);
		put_item(16'sh8000, 1'b0);
		put_item(16'sh0000, 1'b1);
		wait_drained();

		// Full band-pass cascade with coefficients at the top drives saturation.
		set_regs(CFG_W'(rcbf_pkg::MODE_BP), 16'd8, 16'hFFFF, 16'hFFFF);
		put_item(16'sh7FFF, 1'b1);
		put_item(16'sh8000, 1'b0);
		put_item(16'sh7FFF, 1'b0);
		put_item(16'sh8000, 1'b0);
		put_item(16'sh7FFF, 1'b0);
		wait_drained();

		set_regs(CFG_W'(rcbf_pkg::MODE_HP), 16'd8, 16'hFFFF, 16'h0000);
		put_item(16'sh7FFF, 1'b0);
		put_item(16'sh8000, 1'b0);
		put_item(16'sh7FFF, 1'b0);
		put_item(16'sh8000, 1'b0);
		wait_drained();

		set_regs(CFG_W'(rcbf_pkg::MODE_LP), 16'd1, 16'h0000, 16'h0000);
		put_item(-16'sd1, 1'b0);
		put_item(16'sd1, 1'b0);
		put_item(16'sh8000, 1'b1);
		wait_drained();

		// Mode three acts as band-pass, and a stage count of zero as one.
		set_regs(16'd3, 16'd0, 16'h8000, 16'h8000);
		put_item(16'sh4000, 1'b0);
		put_item(-16'sh4000, 1'b0);
		put_item(16'sh7FFF, 1'b0);
		wait_drained();

		// Stage counts above the cascade depth are clipped to it.
		set_regs(CFG_W'(rcbf_pkg::MODE_LP), 16'd15, 16'h0001, 16'hFFFF);
		put_item(16'sh7FFF, 1'b1);
		put_item(16'sh7FFF, 1'b0);
		put_item(16'sh8000, 1'b0);
		wait_drained();

		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			set_regs(add_noise(CFG_W'($urandom_range(0, 3)), 2), add_noise(pick_stages(), 4),
				pick_coef(), pick_coef());
			span = $urandom_range(60, 180);
			style = $urandom_range(0, 3);
			if (phase == 2) begin
				// Output held off while the input keeps offering back to back.
				hold_req = 1'b1;
				burst_left = 40;
			end
			for (int j = 0; j < span; j++) begin
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) != 0)
						idle_src($urandom_range(1, 20));
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				kind = ($urandom_range(0, 9) < 7) ? style : $urandom_range(0, 3);
				clr = (j == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
				put_item(pick_sample(kind, last_sample), clr);
			end
			wait_drained();
			phase++;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d items (%0d clearing the stages) over %0d register settings",
			items_sent, clears_sent, settings_used);
		$display("%0d results compared, including a long output hold-off", compared);
		if (fails == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rcbf_pkg.sv
rtl/rcbf_hp_cell.sv
rtl/rcbf_lp_cell.sv
rtl/cascaded_rc_band_filter_core.sv
sim/rcbf_result_checker.sv
sim/cascaded_rc_band_filter_core_test.sv
